// ===== rtl/flms_pkg.sv =====
// Shared types, constants and helper functions of the fuzzy label match scorer.
// Used by the configuration block, the window cells and the top level.
package flms_pkg;

  localparam int QBYTES        = 16;
  localparam int QUERY_MAX_DEF = 16;
  localparam int LABEL_MAX_DEF = 256;
  localparam int QLEN_W        = 5;
  localparam int APB_AW        = 5;
  localparam int APB_DW        = 64;

  localparam logic [7:0] SLASH = 8'h2F;

  localparam logic [1:0] REG_QUERY_LENGTH = 2'd0;
  localparam logic [1:0] REG_QUERY_LOW    = 2'd1;
  localparam logic [1:0] REG_QUERY_HIGH   = 2'd2;

  localparam logic [1:0] CAT_PREFIX   = 2'd0;
  localparam logic [1:0] CAT_WORD     = 2'd1;
  localparam logic [1:0] CAT_SUBSEQ   = 2'd2;

  typedef struct packed {
    logic [QLEN_W-1:0]          length;
    logic [QBYTES-1:0][7:0]     bytes;
  } query_cfg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic       use_cell;
    logic       need_mark;
    logic [7:0] exp_byte;
  } cell_rule_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

// ===== rtl/flms_cfg.sv =====
// APB register block holding the query length and the sixteen query bytes.
// Depends on flms_pkg for the register codes and the configuration struct.
module flms_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [flms_pkg::APB_AW-1:0] paddr,
  input  logic [flms_pkg::APB_DW-1:0] pwdata,
  output logic [flms_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output flms_pkg::query_cfg_t        cfg
);
  import flms_pkg::*;

  logic [QLEN_W-1:0] query_length;
  logic [63:0]       query_low;
  logic [63:0]       query_high;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length <= '0;
      query_low    <= '0;
      query_high   <= '0;
    end else if (wr) begin
      unique case (paddr[4:3])
        REG_QUERY_LENGTH: query_length <= pwdata[QLEN_W-1:0];
        REG_QUERY_LOW:    query_low    <= pwdata;
        REG_QUERY_HIGH:   query_high   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_QUERY_LENGTH: prdata = {{(APB_DW-QLEN_W){1'b0}}, query_length};
      REG_QUERY_LOW:    prdata = query_low;
      REG_QUERY_HIGH:   prdata = query_high;
      default:          prdata = '0;
    endcase
  end

  assign cfg.length = query_length;
  assign cfg.bytes  = {query_high, query_low};

endmodule

// ===== rtl/flms_cell.sv =====
// One cell of the recent-byte window: holds a folded byte and its boundary mark.
// Compares the byte it takes in against its query byte; depends on flms_pkg.
module flms_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  flms_pkg::cell_ctrl_t ctrl,
  input  flms_pkg::cell_rule_t rule,
  input  logic [7:0]           in_byte,
  input  logic                 in_mark,
  input  logic                 ok_in,
  output logic [7:0]           out_byte,
  output logic                 out_mark,
  output logic                 ok_out
);
  import flms_pkg::*;

  logic own_ok;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      out_byte <= '0;
      out_mark <= 1'b0;
    end else if (ctrl.shift) begin
      out_byte <= in_byte;
      out_mark <= in_mark;
    end
  end

  // The comparison looks at the value the cell takes in with this shift.
  assign own_ok = !rule.use_cell ||
                  ((in_byte == rule.exp_byte) && (!rule.need_mark || in_mark));
  assign ok_out = ok_in && own_ok;

endmodule

// ===== rtl/fuzzy_label_match_scorer.sv =====
// Top level of the fuzzy label match scorer: window cell chain, greedy tracker,
// result register. Depends on flms_pkg, flms_cfg and flms_cell.
//
// The block takes one label byte per cycle and gives one score request on each
// label's last byte, in the cycle after that byte is taken. A row of QUERY_MAX
// cells shifts the recent folded bytes and checks the word-boundary prefix in
// the same cycle, while a greedy pointer tracks the subsequence match. A single
// output register holds the score; while it waits to be taken the input stalls,
// and the next byte enters in the same cycle that the score is taken.
// The query is written over APB at byte addresses 0, 8 and 16; the user must
// write it only while no label is in flight, as the block does not enforce this.
module fuzzy_label_match_scorer #(
  parameter int QUERY_MAX = flms_pkg::QUERY_MAX_DEF,
  parameter int LABEL_MAX = flms_pkg::LABEL_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // entry_index [15:0], label_byte [23:16]
  input  logic [23:0]                 s_tdata,
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // result_entry [15:0], start_res [23:16], span [31:24], gaps [39:32]
  output logic [39:0]                 m_tdata,
  // matched [0], category [2:1], too_long [3]
  output logic [3:0]                  m_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [flms_pkg::APB_AW-1:0] paddr,
  input  logic [flms_pkg::APB_DW-1:0] pwdata,
  output logic [flms_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import flms_pkg::*;

  localparam int POS_W = $clog2(LABEL_MAX + 1);
  localparam int CAP   = (LABEL_MAX - 1) > 255 ? 255 : (LABEL_MAX - 1);

  query_cfg_t        cfg;
  logic [QLEN_W-1:0] len;
  logic [7:0]        qf [QBYTES];

  flms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign len = (cfg.length > QLEN_W'(QUERY_MAX)) ? QLEN_W'(QUERY_MAX) : cfg.length;

  for (genvar k = 0; k < QBYTES; k++) begin : g_fold
    assign qf[k] = fold(cfg.bytes[k]);
  end

  logic [15:0] in_entry;
  logic [7:0]  in_byte;
  logic [7:0]  in_low;
  logic        acc;
  logic        take;
  logic        fin;

  assign in_entry = s_tdata[15:0];
  assign in_byte  = s_tdata[23:16];
  assign in_low   = fold(in_byte);
  assign s_tready = !m_tvalid || m_tready;
  assign acc      = s_tvalid && s_tready;
  assign take     = acc && !(s_tlast && (in_byte == SLASH));
  assign fin      = acc && s_tlast;

  logic             prev_alnum;
  logic [POS_W-1:0] pos;
  logic             found;
  logic             at_zero;
  logic [7:0]       wstart;
  logic             started;
  logic [7:0]       sstart;
  logic [QLEN_W-1:0] qp;
  logic [7:0]       lastpos;
  logic             too_long;

  cell_ctrl_t ctrl;
  logic [7:0] win_byte [QUERY_MAX];
  logic       win_mark [QUERY_MAX];
  logic       ok_chain [QUERY_MAX+1];

  assign ctrl.shift  = take;
  assign ctrl.clear  = fin;
  assign ok_chain[0] = 1'b1;

  for (genvar i = 0; i < QUERY_MAX; i++) begin : g_cell
    cell_rule_t        rule;
    logic [QLEN_W-1:0] qidx;
    logic [7:0]        nb;
    logic              nm;

    assign qidx           = len - QLEN_W'(1) - QLEN_W'(i);
    assign rule.use_cell  = QLEN_W'(i) < len;
    assign rule.need_mark = (QLEN_W'(i) + QLEN_W'(1)) == len;
    assign rule.exp_byte  = qf[qidx[3:0]];

    if (i == 0) begin : g_head
      assign nb = in_low;
      assign nm = !prev_alnum;
    end else begin : g_body
      assign nb = win_byte[i-1];
      assign nm = win_mark[i-1];
    end

    flms_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .rule     (rule),
      .in_byte  (nb),
      .in_mark  (nm),
      .ok_in    (ok_chain[i]),
      .out_byte (win_byte[i]),
      .out_mark (win_mark[i]),
      .ok_out   (ok_chain[i+1])
    );
  end

  logic [7:0]        p;
  logic [POS_W:0]    pos_inc;
  logic [POS_W:0]    len_ext;
  logic [7:0]        lenm1;
  logic              word_hit;
  logic              found_next;
  logic              at_zero_next;
  logic [7:0]        wstart_next;
  logic              started_next;
  logic [7:0]        sstart_next;
  logic [QLEN_W-1:0] qp_next;
  logic [7:0]        lastpos_next;
  logic              too_long_next;
  logic [POS_W-1:0]  pos_next;

  assign p       = (pos > POS_W'(CAP)) ? 8'(CAP) : 8'(pos);
  assign pos_inc = {1'b0, pos} + (POS_W+1)'(1);
  assign len_ext = (POS_W+1)'(len);
  assign lenm1   = 8'(len) - 8'd1;

  assign word_hit = take && (len != '0) && !found && (pos_inc >= len_ext) &&
                    ok_chain[QUERY_MAX];

  always_comb begin
    found_next    = found;
    at_zero_next  = at_zero;
    wstart_next   = wstart;
    started_next  = started;
    sstart_next   = sstart;
    qp_next       = qp;
    lastpos_next  = lastpos;
    too_long_next = too_long;
    pos_next      = pos;
    if (word_hit) begin
      found_next   = 1'b1;
      at_zero_next = (pos_inc == len_ext);
      wstart_next  = (p >= lenm1) ? (p - lenm1) : 8'd0;
    end
    if (take) begin
      if (pos >= POS_W'(LABEL_MAX)) begin
        too_long_next = 1'b1;
      end else begin
        pos_next = pos + POS_W'(1);
      end
      if (len != '0) begin
        if (!started) begin
          if (in_low == qf[0]) begin
            started_next = 1'b1;
            sstart_next  = p;
            lastpos_next = p;
            qp_next      = QLEN_W'(1);
          end
        end else if ((qp < len) && (in_low == qf[qp[3:0]])) begin
          lastpos_next = p;
          qp_next      = qp + QLEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || fin) begin
      prev_alnum <= 1'b0;
      pos        <= '0;
      found      <= 1'b0;
      at_zero    <= 1'b0;
      wstart     <= '0;
      started    <= 1'b0;
      sstart     <= '0;
      qp         <= '0;
      lastpos    <= '0;
      too_long   <= 1'b0;
    end else begin
      if (take) begin
        prev_alnum <= is_alnum(in_byte);
      end
      pos      <= pos_next;
      found    <= found_next;
      at_zero  <= at_zero_next;
      wstart   <= wstart_next;
      started  <= started_next;
      sstart   <= sstart_next;
      qp       <= qp_next;
      lastpos  <= lastpos_next;
      too_long <= too_long_next;
    end
  end

  logic       r_matched;
  logic [1:0] r_cat;
  logic [7:0] r_start;
  logic [7:0] r_span;
  logic [7:0] r_gaps;
  logic [8:0] span1;

  always_comb begin
    r_matched = 1'b0;
    r_cat     = CAT_PREFIX;
    r_start   = '0;
    r_span    = '0;
    r_gaps    = '0;
    span1     = {1'b0, lastpos_next - sstart_next} + 9'd1;
    if (len != '0) begin
      if (found_next) begin
        r_matched = 1'b1;
        if (!at_zero_next) begin
          r_cat   = CAT_WORD;
          r_start = wstart_next;
          r_span  = lenm1;
        end
      end else if (started_next && (qp_next >= len)) begin
        r_matched = 1'b1;
        r_cat     = CAT_SUBSEQ;
        r_start   = sstart_next;
        r_span    = lastpos_next - sstart_next;
        r_gaps    = (span1 > 9'(len)) ? 8'(span1 - 9'(len)) : 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      m_tdata <= {r_gaps, r_span, r_start, in_entry};
      m_tuser <= {too_long_next, r_cat, r_matched};
    end
  end

endmodule

// ===== dv/fuzzy_label_match_scorer_checker.sv =====
`timescale 1ns / 1ps
// Checker for the fuzzy label match scorer: watches the APB writes, the label
// byte stream and the score stream, predicts every score and compares it.
// Depends on flms_pkg for the register and category codes.
module fuzzy_label_match_scorer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic [3:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          n_prefix,
  output int          n_word,
  output int          n_subseq,
  output int          n_miss,
  output int          n_long
);

  localparam int QMAX = flms_pkg::QUERY_MAX_DEF;
  localparam int LMAX = flms_pkg::LABEL_MAX_DEF;

  typedef struct packed {
    logic [15:0] entry;
    logic        matched;
    logic [1:0]  cat;
    logic [7:0]  start;
    logic [7:0]  span;
    logic [7:0]  gaps;
    logic        too_long;
  } score_t;

  logic [4:0]  q_len_reg;
  logic [63:0] q_low;
  logic [63:0] q_high;

  logic [7:0]  win_byte [QMAX];
  logic        win_mark [QMAX];
  logic        prev_alnum;
  logic [8:0]  pos_cnt;
  logic        word_found;
  logic        word_at_zero;
  logic [7:0]  word_start;
  logic        sub_started;
  logic [7:0]  sub_start;
  logic [4:0]  qptr;
  logic [7:0]  last_pos;
  logic        long_flag;

  score_t      expected_scores [$];
  score_t      got;
  score_t      want;
  int          fails, c_prefix, c_word, c_subseq, c_miss, c_long;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic int query_len_used();
    return (q_len_reg > 16) ? 16 : int'(q_len_reg);
  endfunction

  function automatic logic [7:0] query_char(input int k);
    logic [63:0] w;
    w = (k < 8) ? q_low : q_high;
    return lower_ascii(w[8*(k%8) +: 8]);
  endfunction

  task automatic clear_label();
    for (int i = 0; i < QMAX; i++) begin
      win_byte[i] = 8'h00;
      win_mark[i] = 1'b0;
    end
    prev_alnum   = 1'b0;
    pos_cnt      = '0;
    word_found   = 1'b0;
    word_at_zero = 1'b0;
    word_start   = '0;
    sub_started  = 1'b0;
    sub_start    = '0;
    qptr         = '0;
    last_pos     = '0;
    long_flag    = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] raw);
    int len, pos, p;
    logic [7:0] low;
    logic same;
    len = query_len_used();
    low = lower_ascii(raw);
    pos = int'(pos_cnt);
    p   = (pos > 255) ? 255 : pos;
    if (pos >= LMAX) begin
      long_flag = 1'b1;
    end
    for (int i = QMAX - 1; i > 0; i--) begin
      win_byte[i] = win_byte[i-1];
      win_mark[i] = win_mark[i-1];
    end
    win_byte[0] = low;
    win_mark[0] = !prev_alnum;
    prev_alnum  = is_word_char(raw);

    if (len > 0 && !word_found && pos + 1 >= len && win_mark[len-1]) begin
      same = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (win_byte[len-1-k] != query_char(k)) begin
          same = 1'b0;
        end
      end
      if (same) begin
        word_found   = 1'b1;
        word_at_zero = (pos + 1 == len);
        word_start   = (p >= len - 1) ? 8'(p - (len - 1)) : 8'd0;
      end
    end

    if (len > 0) begin
      if (!sub_started) begin
        if (low == query_char(0)) begin
          sub_started = 1'b1;
          sub_start   = 8'(p);
          last_pos    = 8'(p);
          qptr        = 5'd1;
        end
      end else if (qptr < len && low == query_char(qptr)) begin
        last_pos = 8'(p);
        qptr     = qptr + 5'd1;
      end
    end

    if (pos_cnt < LMAX) begin
      pos_cnt = pos_cnt + 9'd1;
    end
  endtask

  function automatic score_t score_label(input logic [15:0] entry);
    score_t r;
    int len, sp;
    len        = query_len_used();
    r          = '0;
    r.entry    = entry;
    r.too_long = long_flag;
    if (len > 0) begin
      if (word_found) begin
        r.matched = 1'b1;
        if (!word_at_zero) begin
          r.cat   = flms_pkg::CAT_WORD;
          r.start = word_start;
          r.span  = 8'(len - 1);
        end else begin
          r.cat = flms_pkg::CAT_PREFIX;
        end
      end else if (sub_started && qptr >= len) begin
        r.matched = 1'b1;
        r.cat     = flms_pkg::CAT_SUBSEQ;
        r.start   = sub_start;
        sp        = int'(last_pos) - int'(sub_start);
        r.span    = 8'(sp);
        r.gaps    = (sp + 1 > len) ? 8'(sp + 1 - len) : 8'd0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      q_len_reg = '0;
      q_low     = '0;
      q_high    = '0;
      clear_label();
      expected_scores.delete();
      fails    = 0;
      c_prefix = 0;
      c_word   = 0;
      c_subseq = 0;
      c_miss   = 0;
      c_long   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          flms_pkg::REG_QUERY_LENGTH: q_len_reg = pwdata[4:0];
          flms_pkg::REG_QUERY_LOW:    q_low     = pwdata;
          flms_pkg::REG_QUERY_HIGH:   q_high    = pwdata;
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        if (!(s_tlast && s_tdata[23:16] == flms_pkg::SLASH)) begin
          absorb_byte(s_tdata[23:16]);
        end
        if (s_tlast) begin
          expected_scores.insert(expected_scores.size(), score_label(s_tdata[15:0]));
          clear_label();
        end
      end

      if (m_tvalid && m_tready) begin
        got.entry    = m_tdata[15:0];
        got.start    = m_tdata[23:16];
        got.span     = m_tdata[31:24];
        got.gaps     = m_tdata[39:32];
        got.matched  = m_tuser[0];
        got.cat      = m_tuser[2:1];
        got.too_long = m_tuser[3];
        if (expected_scores.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: score for entry %0d arrived with none expected",
                     $realtime, got.entry);
          end
        end else begin
          want = expected_scores.pop_front();
          if (want.too_long) c_long++;
          if (!want.matched) c_miss++;
          else if (want.cat == flms_pkg::CAT_PREFIX) c_prefix++;
          else if (want.cat == flms_pkg::CAT_WORD) c_word++;
          else c_subseq++;
          if (got.entry !== want.entry || got.matched !== want.matched ||
              got.cat !== want.cat || got.start !== want.start ||
              got.span !== want.span || got.gaps !== want.gaps ||
              got.too_long !== want.too_long) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: score mismatch, expected entry %0d m %0b cat %0d start %0d",
                       $realtime, want.entry, want.matched, want.cat, want.start);
              $display("    span %0d gaps %0d long %0b; got entry %0d m %0b cat %0d",
                       want.span, want.gaps, want.too_long, got.entry, got.matched,
                       got.cat);
              $display("    start %0d span %0d gaps %0d long %0b",
                       got.start, got.span, got.gaps, got.too_long);
            end
          end
        end
      end
    end
    pending    <= expected_scores.size();
    fail_count <= fails;
    n_prefix   <= c_prefix;
    n_word     <= c_word;
    n_subseq   <= c_subseq;
    n_miss     <= c_miss;
    n_long     <= c_long;
  end

endmodule

// ===== dv/fuzzy_label_match_scorer_tb.sv =====
`timescale 1ns / 1ps
// Top of the fuzzy label match scorer testbench: clock, reset, APB query setup,
// label byte stimulus and score sink. Depends on flms_pkg, the block and the checker.
module fuzzy_label_match_scorer_tb;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;

  wire         s_tready;
  wire         m_tvalid;
  wire  [39:0] m_tdata;
  wire  [3:0]  m_tuser;
  wire  [63:0] prdata;
  wire         pready;

  int fail_count, pending, n_prefix, n_word, n_subseq, n_miss, n_long;

  logic       quiet_sender = 1'b0;
  logic       quiet_receiver = 1'b0;
  logic       hold_req = 1'b0;
  int         bytes_sent = 0;
  int         cur_len = 0;
  logic [7:0] label_q [$];
  logic [7:0] query_text [16];

  fuzzy_label_match_scorer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  fuzzy_label_match_scorer_checker score_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .fail_count(fail_count), .pending(pending), .n_prefix(n_prefix), .n_word(n_word),
    .n_subseq(n_subseq), .n_miss(n_miss), .n_long(n_long)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("fuzzy_label_match_scorer_tb: done, errors");
    $finish;
  end

  // The score sink; a hold request makes it refuse scores for a long stretch.
  initial begin
    int gap;
    forever begin
      if (hold_req) begin
        gap = 300;
        hold_req <= 1'b0;
      end else begin
        gap = quiet_receiver ? 0 : $urandom_range(0, 10);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_query(input logic [4:0] len);
    logic [63:0] lo, hi;
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = query_text[k];
      hi[8*k +: 8] = query_text[k+8];
    end
    apb_write(flms_pkg::REG_QUERY_LENGTH, {59'd0, len});
    apb_write(flms_pkg::REG_QUERY_LOW, lo);
    apb_write(flms_pkg::REG_QUERY_HIGH, hi);
    cur_len = (len > 16) ? 16 : int'(len);
  endtask

  task automatic send_byte(input logic [15:0] entry, input logic [7:0] b, input logic last);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, entry};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_label(input logic [15:0] entry);
    int n;
    n = label_q.size();
    for (int i = 0; i < n; i++) begin
      send_byte((i == n - 1) ? entry : 16'($urandom_range(0, 65535)), label_q[i], i == n - 1);
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    label_q.insert(label_q.size(), b);
  endtask

  task automatic send_text(input logic [15:0] entry, input string txt);
    label_q.delete();
    for (int i = 0; i < txt.len(); i++) begin
      add_byte(txt[i]);
    end
    send_label(entry);
  endtask

  function automatic logic [7:0] any_case(input logic [7:0] c);
    logic alpha;
    alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    return (alpha && $urandom_range(0, 1) == 1) ? (c ^ 8'h20) : c;
  endfunction

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(0, 5))
      0: return "_";
      1: return "-";
      2: return " ";
      3: return ".";
      4: return "/";
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_filler();
    case ($urandom_range(0, 5))
      0: return any_case(query_text[$urandom_range(0, 15)]);
      1: return pick_separator();
      2: return 8'($urandom_range(8'h61, 8'h7A));
      3: return 8'($urandom_range(8'h30, 8'h39));
      4: return 8'($urandom_range(8'h41, 8'h5A));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic build_label(input logic want_long);
    int kind, drop;
    label_q.delete();
    kind = want_long ? 99 : $urandom_range(0, 19);
    if (kind < 4) begin
      for (int k = 0; k < cur_len; k++) add_byte(any_case(query_text[k]));
    end else if (kind < 8) begin
      repeat ($urandom_range(0, 5)) add_byte(pick_filler());
      add_byte(pick_separator());
      for (int k = 0; k < cur_len; k++) add_byte(any_case(query_text[k]));
    end else if (kind < 13) begin
      for (int k = 0; k < cur_len; k++) begin
        repeat ($urandom_range(0, 3)) add_byte(pick_filler());
        add_byte(any_case(query_text[k]));
      end
    end else if (kind < 15) begin
      drop = (cur_len > 0) ? $urandom_range(0, cur_len - 1) : 0;
      for (int k = 0; k < cur_len; k++) begin
        add_byte((k == drop) ? pick_filler() : any_case(query_text[k]));
      end
    end else if (kind < 19 || (kind == 19 && $urandom_range(0, 3) != 0)) begin
      repeat ($urandom_range(1, 12)) add_byte(pick_filler());
    end else begin
      repeat ($urandom_range(240, 300)) add_byte(pick_filler());
      for (int k = 0; k < cur_len; k++) begin
        repeat ($urandom_range(0, 2)) add_byte(pick_filler());
        add_byte(any_case(query_text[k]));
      end
    end
    repeat ($urandom_range(0, 4)) add_byte(pick_filler());
    if ($urandom_range(0, 3) == 0) add_byte(flms_pkg::SLASH);
    if (label_q.size() == 0) add_byte(pick_filler());
  endtask

  initial begin
    string       seed_word;
    logic [4:0]  len;
    int          target;
    logic [7:0]  one_byte;
    seed_word = "AbC";
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < 16; k++) begin
      query_text[k] = (k < 3) ? seed_word[k] : 8'($urandom_range(0, 255));
    end
    load_query(5'd3);
    send_text(16'h0000, "abc");
    send_text(16'hFFFF, "x-ABC");
    send_text(16'($urandom_range(0, 65535)), "xAyBzc/");
    send_text(16'($urandom_range(0, 65535)), "/");
    send_text(16'($urandom_range(0, 65535)), "zabc");
    label_q.delete();
    add_byte(8'h00);
    add_byte(8'hFF);
    send_label(16'($urandom_range(0, 65535)));
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: len = 5'd0;
        1: len = 5'd1;
        2: len = 5'd16;
        3: len = 5'd31;
        default: len = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(1, 8));
      endcase
      for (int k = 0; k < 16; k++) begin
        if (ph == 0 || ph == 3) begin
          query_text[k] = 8'($urandom_range(0, 255));
        end else if ($urandom_range(0, 3) == 0) begin
          query_text[k] = pick_separator();
        end else begin
          query_text[k] = any_case(8'($urandom_range(8'h61, 8'h7A)));
        end
      end
      load_query(len);
      target = bytes_sent + 120;
      if (ph == 2 || ph == 6) begin
        build_label(1'b1);
        send_label(16'($urandom_range(0, 65535)));
      end
      while (bytes_sent < target) begin
        quiet_sender = ($urandom_range(0, 4) == 0);
        quiet_receiver <= ($urandom_range(0, 4) == 0);
        build_label(1'b0);
        send_label(16'($urandom_range(0, 65535)));
      end
      quiet_sender = 1'b0;
      settle();
    end

    // Back pressure: single-byte names keep coming while the sink holds off.
    query_text[0] = "a";
    load_query(5'd1);
    quiet_sender = 1'b1;
    hold_req <= 1'b1;
    for (int i = 0; i < 60; i++) begin
      case ($urandom_range(0, 3))
        0: one_byte = "a";
        1: one_byte = "A";
        2: one_byte = "b";
        default: one_byte = flms_pkg::SLASH;
      endcase
      label_q.delete();
      add_byte(one_byte);
      send_label(16'($urandom_range(0, 65535)));
    end
    quiet_sender = 1'b0;
    settle();

    $display("Sent %0d label bytes; scores checked: %0d prefix, %0d word start,",
             bytes_sent, n_prefix, n_word);
    $display("%0d subsequence, %0d unmatched; %0d names ran past the position range.",
             n_subseq, n_miss, n_long);
    if (fail_count == 0) begin
      $display("fuzzy_label_match_scorer_tb: done, clean");
    end else begin
      $display("fuzzy_label_match_scorer_tb: done, errors");
    end
    $finish;
  end

endmodule
